### src/gfd_pkg.sv
// shared types, constants and the crc-16/xmodem byte update for the gamepad deframer
// no dependencies; imported by gfd_parser, gfd_out_reg and the top level
package gfd_pkg;

  localparam logic [7:0]  START_BYTE = 8'h7B;
  localparam logic [7:0]  END_BYTE   = 8'h7D;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'h0000;

  typedef enum logic [1:0] {
    KIND_BUTTON = 2'd0,
    KIND_AXIS   = 2'd1,
    KIND_COMMIT = 2'd2,
    KIND_DROP   = 2'd3
  } kind_t;

  typedef enum logic [8:0] {
    PH_HUNT   = 9'b000000001,
    PH_CTRL   = 9'b000000010,
    PH_BCOUNT = 9'b000000100,
    PH_BUTTON = 9'b000001000,
    PH_ACOUNT = 9'b000010000,
    PH_AXES   = 9'b000100000,
    PH_END    = 9'b001000000,
    PH_CRCLO  = 9'b010000000,
    PH_CRCHI  = 9'b100000000
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         controller;
    logic [7:0]         position;
    logic [7:0]         button_bits;
    logic signed [15:0] axis_first;
    logic signed [15:0] axis_second;
    logic [7:0]         buttons_total;
    logic [7:0]         axes_total;
    logic               last;
  } result_t;

  // msb-first crc over one byte, poly 0x1021
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### src/gfd_in_reg.sv
// input register stage: holds one received word until the parser takes it
// depends on nothing but the clock and reset
module gfd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       vld,
  output logic [7:0] rx_byte
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign vld     = vld_r;
  assign rx_byte = byte_r;

endmodule

### src/gfd_parser.sv
// frame parser state machine with running crc; one word per take
// depends on gfd_pkg
module gfd_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  output logic            res_vld,
  output gfd_pkg::result_t res
);
  import gfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  buttons_r, buttons_nxt;
  logic [7:0]  axes_r, axes_nxt;
  logic [9:0]  left_r, left_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] crc_upd;
  logic [9:0]  left_dec;

  assign crc_upd  = crc16_byte(crc_r, rx_byte);
  assign left_dec = left_r - 10'd1;

  always_comb begin
    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    ctrl_nxt    = ctrl_r;
    buttons_nxt = buttons_r;
    axes_nxt    = axes_r;
    left_nxt    = left_r;
    count_nxt   = count_r;
    partial_nxt = partial_r;
    crc_lo_nxt  = crc_lo_r;
    res_vld     = 1'b0;
    res         = '0;
    res.controller = ctrl_r;

    unique case (phase_r)
      PH_CTRL: begin
        ctrl_nxt  = rx_byte;
        crc_nxt   = crc_upd;
        phase_nxt = PH_BCOUNT;
      end
      PH_BCOUNT: begin
        buttons_nxt = rx_byte;
        crc_nxt     = crc_upd;
        left_nxt    = 10'(({2'b00, rx_byte} + 10'd7) >> 3);
        count_nxt   = '0;
        phase_nxt   = (rx_byte == 8'd0) ? PH_ACOUNT : PH_BUTTON;
      end
      PH_BUTTON: begin
        crc_nxt         = crc_upd;
        res_vld         = 1'b1;
        res.kind        = KIND_BUTTON;
        res.position    = count_r;
        res.button_bits = rx_byte;
        count_nxt       = count_r + 8'd1;
        left_nxt        = left_dec;
        if (left_dec == 10'd0) begin
          phase_nxt = PH_ACOUNT;
        end
      end
      PH_ACOUNT: begin
        axes_nxt    = rx_byte;
        crc_nxt     = crc_upd;
        left_nxt    = {rx_byte, 2'b00};
        count_nxt   = '0;
        partial_nxt = '0;
        phase_nxt   = (rx_byte == 8'd0) ? PH_END : PH_AXES;
      end
      PH_AXES: begin
        crc_nxt = crc_upd;
        if (left_r[1:0] == 2'd1) begin
          res_vld         = 1'b1;
          res.kind        = KIND_AXIS;
          res.position    = count_r;
          res.axis_first  = partial_r[23:8];
          res.axis_second = {partial_r[7:0], rx_byte};
          count_nxt       = count_r + 8'd1;
          partial_nxt     = '0;
        end else begin
          partial_nxt = {partial_r[15:0], rx_byte};
        end
        left_nxt = left_dec;
        if (left_dec == 10'd0) begin
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        if (rx_byte == END_BYTE) begin
          crc_nxt   = crc_upd;
          phase_nxt = PH_CRCLO;
        end else begin
          res_vld   = 1'b1;
          res.kind  = KIND_DROP;
          res.last  = 1'b1;
          phase_nxt = PH_HUNT;
        end
      end
      PH_CRCLO: begin
        crc_lo_nxt = rx_byte;
        phase_nxt  = PH_CRCHI;
      end
      PH_CRCHI: begin
        res_vld  = 1'b1;
        res.last = 1'b1;
        if ({rx_byte, crc_lo_r} == crc_r) begin
          res.kind          = KIND_COMMIT;
          res.buttons_total = buttons_r;
          res.axes_total    = axes_r;
        end else begin
          res.kind = KIND_DROP;
        end
        phase_nxt = PH_HUNT;
      end
      default: begin
        // hunting, and any code outside the one-hot set
        phase_nxt = PH_HUNT;
        if (rx_byte == START_BYTE) begin
          crc_nxt   = crc16_byte(CRC_INIT, rx_byte);
          phase_nxt = PH_CTRL;
        end
      end
    endcase
    if (!take) begin
      res_vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      crc_r     <= CRC_INIT;
      ctrl_r    <= '0;
      buttons_r <= '0;
      axes_r    <= '0;
      left_r    <= '0;
      count_r   <= '0;
      partial_r <= '0;
      crc_lo_r  <= '0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      crc_r     <= crc_nxt;
      ctrl_r    <= ctrl_nxt;
      buttons_r <= buttons_nxt;
      axes_r    <= axes_nxt;
      left_r    <= left_nxt;
      count_r   <= count_nxt;
      partial_r <= partial_nxt;
      crc_lo_r  <= crc_lo_nxt;
    end
  end

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.last |=> phase_r == PH_HUNT)
    else $error("frame end did not return to hunting");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (res.last == (res.kind == KIND_COMMIT || res.kind == KIND_DROP)))
    else $error("last flag disagrees with kind");

  a_crc_order: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_CRCLO |=> phase_r == PH_CRCHI)
    else $error("crc low byte not followed by crc high byte");

endmodule

### src/gfd_out_reg.sv
// result register: holds one result word until the consumer takes it
// depends on gfd_pkg
module gfd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  gfd_pkg::result_t    res,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_controller,
  output logic [7:0]          out_position,
  output logic [7:0]          out_button_bits,
  output logic signed [15:0]  out_axis_first,
  output logic signed [15:0]  out_axis_second,
  output logic [7:0]          out_buttons_total,
  output logic [7:0]          out_axes_total,
  output logic                out_last
);
  import gfd_pkg::*;

  logic    vld_r, vld_nxt;
  result_t res_r;

  assign space   = !vld_r || out_ready;
  assign vld_nxt = load ? 1'b1 : (out_ready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid         = vld_r;
  assign out_kind          = res_r.kind;
  assign out_controller    = res_r.controller;
  assign out_position      = res_r.position;
  assign out_button_bits   = res_r.button_bits;
  assign out_axis_first    = res_r.axis_first;
  assign out_axis_second   = res_r.axis_second;
  assign out_buttons_total = res_r.buttons_total;
  assign out_axes_total    = res_r.axes_total;
  assign out_last          = res_r.last;

endmodule

### src/gamepad_frame_deframer_crc16.sv
// top level of the gamepad frame deframer with crc-16/xmodem check
// depends on gfd_pkg, gfd_in_reg, gfd_parser and gfd_out_reg
module gamepad_frame_deframer_crc16 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_controller,
  output logic [7:0]         out_position,
  output logic [7:0]         out_button_bits,
  output logic signed [15:0] out_axis_first,
  output logic signed [15:0] out_axis_second,
  output logic [7:0]         out_buttons_total,
  output logic [7:0]         out_axes_total,
  output logic               out_last
);
  // Takes one received byte per word and parses frames of the form
  // '{' ctrl nbuttons button-bytes naxes 4-bytes-per-axis '}' crc-lo crc-hi.
  // Button bytes and axis pairs come out as tentative words as they arrive;
  // each frame ends with a commit word (crc matches) or a drop word (bad end
  // byte or crc mismatch), both with out_last set. Bytes outside a frame are
  // ignored until the next '{'. Throughput is one byte per clock while the
  // result register is free or out_ready is high: the crc update for a byte
  // is a combinational eight-step shift network, and the parser state
  // advances on every accepted byte. A byte is held in the input register
  // and its result word, if any, in the result register before out_valid
  // goes high. Ready paths are combinational from out_ready back to in_ready.
  import gfd_pkg::*;

  logic       stage_vld;
  logic [7:0] stage_byte;
  logic       take;
  logic       space;
  logic       res_vld;
  result_t    res;

  // a held byte moves into the parser whenever the result register can accept
  assign take = stage_vld && space;

  gfd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .vld        (stage_vld),
    .rx_byte    (stage_byte)
  );

  // header/payload/trailer parsing and running crc
  gfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (stage_byte),
    .res_vld (res_vld),
    .res     (res)
  );

  // result register toward the consumer
  gfd_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (res_vld),
    .res               (res),
    .space             (space),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_controller    (out_controller),
    .out_position      (out_position),
    .out_button_bits   (out_button_bits),
    .out_axis_first    (out_axis_first),
    .out_axis_second   (out_axis_second),
    .out_buttons_total (out_buttons_total),
    .out_axes_total    (out_axes_total),
    .out_last          (out_last)
  );

endmodule
